>>> rtl/mrhm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared types and constants of the motif region hit matcher.
package mrhm_pkg;

   // Number of window cells, which is the longest motif the window can hold.
   localparam int MAX_MOTIF    = 15;
   // Number of motif symbols the motif register holds.
   localparam int MOTIF_STORED = 15;

   localparam int BASE_W      = 3;
   localparam int REGION_W    = 3;
   localparam int SYM_W       = 2;
   localparam int LEN_W       = 4;
   localparam int MOTIF_W     = 30;
   localparam int HITS_W      = 5;
   localparam int NUM_REGIONS = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 30;
   localparam int TDATA_W     = 8;
   // Width used to compare motif lengths against cell positions.
   localparam int CMP_W       = 6;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MOTIF_BASES  = 1'b0,
      CSR_MOTIF_LENGTH = 1'b1
   } csr_index_type;

   // Data handed from one window cell to the next.
   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              valid;
   } cell_link_type;

   // Shift and clear controls of a cell.
   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/mrhm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One window position: holds one base and its valid bit, passes them on at
// each shift, and ANDs its own compare into the match chain.
module mrhm_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mrhm_pkg::cell_ctrl_type    ctrl,
   input  wire mrhm_pkg::cell_link_type    link_in,
   output      mrhm_pkg::cell_link_type    link_out,
   input  wire logic [mrhm_pkg::SYM_W-1:0] motif_sym,
   input  wire logic                       enable,
   input  wire logic                       match_in,
   output      logic                       match_out
);

   logic [mrhm_pkg::BASE_W-1:0] base_ff;
   logic [mrhm_pkg::BASE_W-1:0] base_in;
   logic                        valid_ff;
   logic                        valid_in;
   logic                        hit_local;

   always_comb begin
      if (ctrl.shift) begin
         valid_in = link_in.valid & ~ctrl.clear;
         base_in  = link_in.base;
      end else begin
         valid_in = valid_ff;
         base_in  = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   // The DNA base must be the complement of the motif symbol; codes with
   // the top bit set are not A, C, G or T and never match.
   assign hit_local = valid_ff && !base_ff[mrhm_pkg::BASE_W-1]
                      && (base_ff[mrhm_pkg::SYM_W-1:0] == ~motif_sym);

   assign match_out     = match_in & (~enable | hit_local);
   assign link_out.base  = base_ff;
   assign link_out.valid = valid_ff;

endmodule

`default_nettype wire

>>> rtl/motif_region_hit_matcher_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Motif region hit matcher.
// DNA bases enter on the req_ stream, one per transfer: tdata carries the base
// code and the region tag, tuser marks the first base of a region (which
// empties the base window first) and tlast marks the last base of an exon.
// For every tlast transfer one result leaves on the rsp_ stream: the 5-bit
// map of regions whose reverse-complemented form contains the motif.
// The motif and its length are set through the csr_ write channel, which
// is always ready; write it only while no item is in flight.
// Throughput is one base per cycle while req_tready is high. A base
// shifts into a chain of window cells at the edge it is accepted, and
// its region tag and tlast enter the compare stage; when it drains, the
// cells' compares fold into the hit map; a tlast loads the result register.
// Reset empties the window, clears the hit map and restores the motif
// registers to zero bases and length one.
// If the receiver stalls, one more tlast item may wait in the compare
// stage behind the result register; after that req_tready drops until the
// result is taken. Items without tlast keep flowing during a stall.
module motif_region_hit_matcher_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Input stream.
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [2:0] base, [5:3] region, [7:6] zero
   input  wire logic [mrhm_pkg::TDATA_W-1:0]    req_tdata,
   // [0] first_of_region
   input  wire logic                            req_tuser,
   input  wire logic                            req_tlast,
   // Result stream.
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [4:0] region_hits, [7:5] zero
   output      logic [mrhm_pkg::TDATA_W-1:0]    rsp_tdata,
   // Configuration writes.
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [mrhm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mrhm_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int N = mrhm_pkg::MAX_MOTIF;

   // Configuration registers.
   logic [mrhm_pkg::MOTIF_W-1:0] motif_bases_ff;
   logic [mrhm_pkg::MOTIF_W-1:0] motif_bases_in;
   logic [mrhm_pkg::LEN_W-1:0]   motif_length_ff;
   logic [mrhm_pkg::LEN_W-1:0]   motif_length_in;
   logic [mrhm_pkg::CMP_W-1:0]   eff_len;

   // Compare stage and result register.
   logic                          s1_vld_ff;
   logic                          s1_vld_in;
   logic [mrhm_pkg::REGION_W-1:0] s1_region_ff;
   logic [mrhm_pkg::REGION_W-1:0] s1_region_in;
   logic                          s1_last_ff;
   logic                          s1_last_in;
   logic [mrhm_pkg::HITS_W-1:0]   hit_map_ff;
   logic [mrhm_pkg::HITS_W-1:0]   hit_map_in;
   logic [mrhm_pkg::HITS_W-1:0]   hit_set;
   logic [mrhm_pkg::HITS_W-1:0]   hit_next;
   logic                          rsp_tvalid_ff;
   logic                          rsp_tvalid_in;
   logic [mrhm_pkg::HITS_W-1:0]   rsp_hits_ff;
   logic [mrhm_pkg::HITS_W-1:0]   rsp_hits_in;

   logic out_free;
   logic s1_go;
   logic accept;
   logic window_hit;

   // Window chain.
   mrhm_pkg::cell_link_type link [N+1];
   mrhm_pkg::cell_ctrl_type ctrl [N];
   logic                    match [N+1];
   logic [N-1:0]            valid_vec;

   // Configuration port.
   assign csr_ready = 1'b1;

   always_comb begin
      motif_bases_in  = motif_bases_ff;
      motif_length_in = motif_length_ff;
      if (csr_valid && csr_ready) begin
         case (mrhm_pkg::csr_index_type'(csr_index))
            mrhm_pkg::CSR_MOTIF_BASES:  motif_bases_in  = csr_data[mrhm_pkg::MOTIF_W-1:0];
            mrhm_pkg::CSR_MOTIF_LENGTH: motif_length_in = csr_data[mrhm_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motif_bases_ff  <= '0;
         motif_length_ff <= mrhm_pkg::LEN_RESET;
      end else begin
         motif_bases_ff  <= motif_bases_in;
         motif_length_ff <= motif_length_in;
      end
   end

   // A length of zero acts as one, and a length beyond the window as the
   // full window.
   always_comb begin
      eff_len = mrhm_pkg::CMP_W'(motif_length_ff);
      if (eff_len == '0) begin
         eff_len = mrhm_pkg::CMP_W'(1);
      end
      if (eff_len > mrhm_pkg::CMP_W'(N)) begin
         eff_len = mrhm_pkg::CMP_W'(N);
      end
   end

   // Handshake. The compare stage drains unless it holds an exon end that
   // the result register cannot take yet.
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign s1_go      = s1_vld_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_vld_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // The newest base enters cell zero as valid; cell zero is never cleared,
   // so a region's first base is kept while the older cells are emptied.
   assign link[0].base  = req_tdata[mrhm_pkg::BASE_W-1:0];
   assign link[0].valid = 1'b1;
   assign match[0]      = 1'b1;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [mrhm_pkg::SYM_W-1:0] motif_sym;
      logic                       enable;

      if (i < mrhm_pkg::MOTIF_STORED) begin : g_stored
         assign motif_sym = motif_bases_ff[mrhm_pkg::SYM_W*i +: mrhm_pkg::SYM_W];
      end else begin : g_beyond
         assign motif_sym = '0;
      end

      assign enable        = mrhm_pkg::CMP_W'(i) < eff_len;
      assign ctrl[i].shift = accept;
      assign ctrl[i].clear = (i == 0) ? 1'b0 : req_tuser;
      assign valid_vec[i]  = link[i+1].valid;

      mrhm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[i]),
         .link_in   (link[i]),
         .link_out  (link[i+1]),
         .motif_sym (motif_sym),
         .enable    (enable),
         .match_in  (match[i]),
         .match_out (match[i+1])
      );
   end

   // The chain end is high when every cell within the motif length holds the
   // complement of its motif symbol; a cell still empty fails the compare.
   assign window_hit = match[N];

   always_comb begin
      hit_set = '0;
      for (int r = 0; r < mrhm_pkg::NUM_REGIONS; r++) begin
         if (s1_region_ff == mrhm_pkg::REGION_W'(r)) begin
            hit_set[r] = window_hit;
         end
      end
      hit_next = hit_map_ff | hit_set;
   end

   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_region_in = s1_region_ff;
      s1_last_in   = s1_last_ff;
      if (accept) begin
         s1_vld_in    = 1'b1;
         s1_region_in = req_tdata[mrhm_pkg::BASE_W +: mrhm_pkg::REGION_W];
         s1_last_in   = req_tlast;
      end else if (s1_go) begin
         s1_vld_in = 1'b0;
      end
   end

   // The map includes the hit of the exon's last base and is cleared when it is
   // loaded into the result register.
   always_comb begin
      hit_map_in    = hit_map_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (s1_go) begin
         if (s1_last_ff) begin
            hit_map_in    = '0;
            rsp_hits_in   = hit_next;
            rsp_tvalid_in = 1'b1;
         end else begin
            hit_map_in = hit_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         hit_map_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         s1_vld_ff     <= s1_vld_in;
         hit_map_ff    <= hit_map_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_region_ff <= s1_region_in;
      s1_last_ff   <= s1_last_in;
      rsp_hits_ff  <= rsp_hits_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(mrhm_pkg::TDATA_W - mrhm_pkg::HITS_W)'(0), rsp_hits_ff};

   // A result appears only after an exon end left the compare stage.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(s1_go && s1_last_ff))
      else $error("result raised without an exon end");

   // The hit map starts empty after every exon end.
   a_map_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_last_ff) |=> (hit_map_ff == '0))
      else $error("hit map not cleared after emit");

   // Valid cells always form a contiguous run from the newest entry.
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + N'(1))) == '0))
      else $error("window valid bits not contiguous");

   // A held exon end behind a stalled result blocks new input.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && s1_last_ff && rsp_tvalid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while exon end is blocked");

endmodule

`default_nettype wire
